/* design/opt_pkg.sv */
package opt_pkg;

  localparam int IN_W       = 48;
  localparam int OUT_W      = 64;
  localparam int LIST_LIMIT = 16;

  localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_FIND   = 3'd1;
  localparam logic [2:0] CMD_MODIFY = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_TOTAL  = 3'd4;
  localparam logic [2:0] CMD_LIST   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [1:0] PRI_HIGH = 2'd2;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  pri;
    logic [19:0] mem;
  } entry_t;

  typedef enum logic [2:0] {
    RES_OK,
    RES_NOTFOUND,
    RES_FULL,
    RES_EMPTY,
    RES_ENTRY,
    RES_MODIFIED,
    RES_TOTAL,
    RES_LIST
  } res_kind_t;

  // controller -> datapath
  typedef struct packed {
    logic      cap;
    logic      rd_issue;
    logic      ptr_load_hit;
    logic      acc_en;
    logic      wr_append;
    logic      wr_modify;
    logic      wr_shift;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      out_load;
    res_kind_t res;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       empty;
    logic       ptr_lt_cnt;
    logic       rd_vld;
    logic       rd_hit;
    logic       out_free;
    logic       list_last;
  } stat_t;

endpackage

/* design/opt_ctrl.sv */
module opt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  opt_pkg::stat_t st,
  output opt_pkg::ctrl_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SUM,
    S_LREAD,
    S_LEMIT,
    S_EMIT,
    S_EMIT_DEL,
    S_SHIFT
  } state_t;

  state_t               state_r, state_nxt;
  opt_pkg::res_kind_t   res_r, res_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.res   = res_r;
    state_nxt = state_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.cap = in_valid;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (st.cmd) inside
          opt_pkg::CMD_ADD: begin
            if (st.full) begin
              res_nxt = opt_pkg::RES_FULL;
            end else begin
              cmd.wr_append = 1'b1;
              cmd.cnt_inc   = 1'b1;
              res_nxt       = opt_pkg::RES_OK;
            end
            state_nxt = S_EMIT;
          end
          opt_pkg::CMD_FIND, opt_pkg::CMD_MODIFY, opt_pkg::CMD_DELETE: state_nxt = S_SCAN;
          opt_pkg::CMD_TOTAL: state_nxt = S_SUM;
          opt_pkg::CMD_LIST: begin
            if (st.empty) begin
              res_nxt   = opt_pkg::RES_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_LREAD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        // stop issuing once the first match is seen so its read data holds
        cmd.rd_issue = st.ptr_lt_cnt && !st.rd_hit;
        if (st.rd_hit) begin
          if (st.cmd == opt_pkg::CMD_MODIFY) begin
            cmd.wr_modify = 1'b1;
            res_nxt       = opt_pkg::RES_MODIFIED;
            state_nxt     = S_EMIT;
          end else if (st.cmd == opt_pkg::CMD_DELETE) begin
            res_nxt   = opt_pkg::RES_ENTRY;
            state_nxt = S_EMIT_DEL;
          end else begin
            res_nxt   = opt_pkg::RES_ENTRY;
            state_nxt = S_EMIT;
          end
        end else if (!st.rd_vld && !st.ptr_lt_cnt) begin
          res_nxt   = opt_pkg::RES_NOTFOUND;
          state_nxt = S_EMIT;
        end
      end
      S_SUM: begin
        cmd.rd_issue = st.ptr_lt_cnt;
        cmd.acc_en   = st.rd_vld;
        if (!st.rd_vld && !st.ptr_lt_cnt) begin
          res_nxt   = opt_pkg::RES_TOTAL;
          state_nxt = S_EMIT;
        end
      end
      S_LREAD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_LEMIT;
      end
      S_LEMIT: begin
        cmd.res = opt_pkg::RES_LIST;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = st.list_last ? S_IDLE : S_LREAD;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT_DEL: begin
        if (st.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.ptr_load_hit = 1'b1;
          state_nxt        = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // close the gap: read entry i+1, write it back at i
        cmd.rd_issue = st.ptr_lt_cnt;
        cmd.wr_shift = st.rd_vld;
        if (!st.rd_vld && !st.ptr_lt_cnt) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= opt_pkg::RES_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

/* design/opt_dp.sv */
module opt_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [opt_pkg::IN_W-1:0]  in_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [opt_pkg::OUT_W-1:0] out_data,
  output logic                      out_last,
  input  opt_pkg::ctrl_t            cmd,
  output opt_pkg::stat_t            st
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LIST_N  =
    CW'((TABLE_DEPTH < opt_pkg::LIST_LIMIT) ? TABLE_DEPTH : opt_pkg::LIST_LIMIT);

  opt_pkg::entry_t mem_r [TABLE_DEPTH];

  logic [2:0]      cap_cmd_r;
  logic [15:0]     cap_id_r;
  logic [1:0]      cap_pri_r;
  logic [19:0]     cap_mem_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   ptr_r;
  logic [IW-1:0]   rd_idx_r;
  logic            rd_vld_r;
  opt_pkg::entry_t rd_data_r;
  logic [23:0]     acc_r;
  logic            out_valid_r;
  logic [opt_pkg::OUT_W-1:0] out_data_r;
  logic            out_last_r;

  logic [1:0]      in_pri;
  logic [24:0]     sum;
  logic [CW-1:0]   rd_next;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  opt_pkg::entry_t wr_data;
  logic [1:0]      o_status;
  logic [15:0]     o_id;
  logic [1:0]      o_pri;
  logic [19:0]     o_mem;
  logic [23:0]     o_total;
  logic            o_last;

  assign in_pri  = (in_data[20:19] > opt_pkg::PRI_HIGH) ? opt_pkg::PRI_HIGH : in_data[20:19];
  assign sum     = {1'b0, acc_r} + {5'b0, rd_data_r.mem};
  assign rd_next = CW'(rd_idx_r) + CW'(1);

  assign st.cmd        = cap_cmd_r;
  assign st.full       = (cnt_r == DEPTH_C);
  assign st.empty      = (cnt_r == '0);
  assign st.ptr_lt_cnt = (ptr_r < cnt_r);
  assign st.rd_vld     = rd_vld_r;
  assign st.rd_hit     = rd_vld_r && (rd_data_r.id == cap_id_r);
  assign st.out_free   = !out_valid_r || out_ready;
  assign st.list_last  = (rd_next == cnt_r) || (rd_next == LIST_N);

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[IW-1:0];
    wr_data = '{id: cap_id_r, pri: cap_pri_r, mem: cap_mem_r};
    if (cmd.wr_append) begin
      wr_en = 1'b1;
    end else if (cmd.wr_modify) begin
      wr_en      = 1'b1;
      wr_addr    = rd_idx_r;
      wr_data.id = rd_data_r.id;
    end else if (cmd.wr_shift) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_r - IW'(1);
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (cmd.rd_issue) begin
      rd_data_r <= mem_r[ptr_r[IW-1:0]];
      rd_idx_r  <= ptr_r[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cap_cmd_r <= in_data[2:0];
      cap_id_r  <= in_data[18:3];
      cap_pri_r <= in_pri;
      cap_mem_r <= in_data[40:21];
    end
    if (cmd.cap) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= sum[24] ? opt_pkg::TOTAL_MAX : sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.cap) begin
        ptr_r <= '0;
      end else if (cmd.ptr_load_hit) begin
        ptr_r <= rd_next;
      end else if (cmd.rd_issue) begin
        ptr_r <= ptr_r + CW'(1);
      end
    end
  end

  always_comb begin
    o_status = opt_pkg::ST_OK;
    o_id     = '0;
    o_pri    = '0;
    o_mem    = '0;
    o_total  = '0;
    o_last   = 1'b1;
    case (cmd.res)
      opt_pkg::RES_NOTFOUND: o_status = opt_pkg::ST_NOTFOUND;
      opt_pkg::RES_FULL:     o_status = opt_pkg::ST_FULL;
      opt_pkg::RES_EMPTY:    o_status = opt_pkg::ST_EMPTY;
      opt_pkg::RES_ENTRY: begin
        o_id  = rd_data_r.id;
        o_pri = rd_data_r.pri;
        o_mem = rd_data_r.mem;
      end
      opt_pkg::RES_MODIFIED: begin
        o_id  = rd_data_r.id;
        o_pri = cap_pri_r;
        o_mem = cap_mem_r;
      end
      opt_pkg::RES_TOTAL: o_total = acc_r;
      opt_pkg::RES_LIST: begin
        o_id   = rd_data_r.id;
        o_pri  = rd_data_r.pri;
        o_mem  = rd_data_r.mem;
        o_last = st.list_last;
      end
      default: o_status = opt_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= {o_total, o_mem, o_pri, o_id, o_status};
      out_last_r <= o_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

/* design/ordered_process_table.sv */
// Ordered process table: up to TABLE_DEPTH entries (id, priority, memory) kept
// in insertion order, with add, find, modify, delete, total and list requests.
// Input channel in_*: one request per accepted beat. Output channel out_*:
// one result per request, or one per listed entry for a list request, with
// out_tlast marking the final result of a request. Unknown commands give none.
// Operation, N = number of stored entries (at most TABLE_DEPTH):
//   add: no table scan before the result register.
//   find / modify: up to N entries scanned, one entry compared per cycle
//   through the single read port of the entry memory.
//   delete: scanned as find, then the result, then the later entries close up
//   at one per cycle; the next request is taken once they have.
//   total: up to N entries summed, one saturating add per cycle.
//   list: each entry is read, then emitted, in a read-then-emit loop.
// The next request is taken while the last result still waits in the output
// register; a stalled receiver holds the block only when it must emit again.
// Reset empties the table (entry count to zero) and drops any pending result.
module ordered_process_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [2:0] command, [18:3] proc_id, [20:19] priority_in, [40:21] memory_in
  input  logic [opt_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [1:0] status, [17:2] found_id, [19:18] found_priority,
  // [39:20] found_memory, [63:40] memory_total
  output logic [opt_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tlast
);

  opt_pkg::ctrl_t ctrl;
  opt_pkg::stat_t stat;

  opt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (stat),
    .cmd      (ctrl)
  );

  opt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .cmd       (ctrl),
    .st        (stat)
  );

endmodule

/* design/opt_checker.sv */
module opt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [opt_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a list run in progress blocks new requests
  a_no_accept_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request accepted in the middle of a list");

  a_mid_list_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[1:0] == opt_pkg::ST_OK && out_tdata[63:40] == '0)
    else $error("non-final result is not a plain entry");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != opt_pkg::ST_OK |-> out_tdata[63:2] == '0 && out_tlast)
    else $error("error result carries data");

endmodule

bind ordered_process_table opt_checker u_opt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
